[hdl/srkt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted keyed record table package
// Shared types for the record cells, the top level and the port checker.
// ----------------------------------------------------------------------------
package srkt_pkg;

   localparam int KEY_W  = 16;
   localparam int NAME_W = 32;
   localparam int QTY_W  = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_ERASE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
      logic [QTY_W-1:0]  qty;
   } rec_type;

   // Broadcast to every cell for the transaction being executed.
   typedef struct packed {
      logic    insert_go;   // insert succeeds: open a slot at the sorted position
      logic    erase_go;    // erase hits: close the gap
      logic    update_go;   // update command: the hit cell adds the change
      rec_type new_rec;     // search key, new name and amount or change
   } cell_ctrl_type;

   typedef struct packed {
      logic below;          // occupied and stored key below the search key
      logic hit;            // occupied and stored key equals the search key
   } cell_flag_type;

endpackage

[hdl/sorted_keyed_record_table_top.sv]
// Flow: an accepted transaction waits in the command register until it executes;
//   the result is registered on execute and rsp_valid rises with it.
// Throughput: one transaction per cycle while the result side does not stall;
//   every cell compares in parallel and shifts in the execute cycle.
// Reset: clears the record count and all handshake state; cell contents are
//   left as they are and count as empty.
// ----------------------------------------------------------------------------
// Sorted keyed record table
// A row of record cells kept in ascending key order. Insert opens a slot at
// the sorted position, erase closes the gap, search and update act on the
// cell whose key matches.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table_top #(
   parameter int ENTRIES    = 16,
   parameter int NAME_CHARS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [15:0]         req_key,
   input  logic [31:0]         req_name_chars,
   input  logic signed [31:0]  req_amount,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_found_name,
   output logic signed [31:0]  rsp_quantity
);
   import srkt_pkg::*;

   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int NAME_BITS = (NAME_CHARS * 8 > NAME_W) ? NAME_W : NAME_CHARS * 8;
   localparam logic [NAME_W-1:0] NAME_MASK =
      (NAME_BITS >= NAME_W) ? {NAME_W{1'b1}}
                            : NAME_W'((64'd1 << NAME_BITS) - 64'd1);

   // Command register: holds the accepted transaction until it executes.
   logic             cmd_valid_ff, cmd_valid_in;
   cmd_type          cmd_ff, cmd_in;
   rec_type          arg_ff, arg_in;

   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [QTY_W-1:0] qty_ff, qty_in;

   logic             accept;
   logic             exec;
   logic             full;
   logic             hit_any;
   logic [NAME_W-1:0] hit_name_or;
   logic [QTY_W-1:0] hit_qty_or;
   cell_ctrl_type    ctrl;

   cell_flag_type    flags    [ENTRIES];
   rec_type          recs     [ENTRIES];
   logic [NAME_W-1:0] hit_names [ENTRIES];
   logic [QTY_W-1:0] hit_qtys [ENTRIES];

   // Execute when a transaction waits and the result register is free or drains.
   assign exec      = cmd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = cmd_valid_ff && !exec;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      if (accept) begin
         cmd_valid_in = 1'b1;
      end else if (exec) begin
         cmd_valid_in = 1'b0;
      end
   end

   // Capture the request; trim the name to its configured length here.
   always_comb begin
      cmd_in = cmd_ff;
      arg_in = arg_ff;
      if (accept) begin
         cmd_in      = cmd_type'(req_command);
         arg_in.key  = req_key;
         arg_in.name = req_name_chars & NAME_MASK;
         arg_in.qty  = req_amount;
      end
   end

   // Collect hit flags and the matching cell's fields over the row.
   always_comb begin
      hit_any     = 1'b0;
      hit_name_or = '0;
      hit_qty_or  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_any     = hit_any | flags[i].hit;
         hit_name_or = hit_name_or | hit_names[i];
         hit_qty_or  = hit_qty_or | hit_qtys[i];
      end
   end

   assign full = (count_ff == CNT_W'(ENTRIES));

   always_comb begin
      ctrl.new_rec   = arg_ff;
      ctrl.insert_go = exec && (cmd_ff == CMD_INSERT) && !full && !hit_any;
      ctrl.erase_go  = exec && (cmd_ff == CMD_ERASE) && hit_any;
      ctrl.update_go = exec && (cmd_ff == CMD_UPDATE);
   end

   // Advance the record count on a successful insert or erase.
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_go) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.erase_go) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result for the executing transaction.
   always_comb begin
      status_in = ST_OK;
      name_in   = '0;
      qty_in    = '0;
      case (cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (hit_any) begin
               status_in = ST_EXISTS;
            end
         end
         CMD_SEARCH: begin
            if (!hit_any) begin
               status_in = ST_NOT_FOUND;
            end else begin
               name_in = hit_name_or;
               qty_in  = hit_qty_or;
            end
         end
         CMD_UPDATE: begin
            if (!hit_any) begin
               status_in = ST_NOT_FOUND;
            end else begin
               qty_in = hit_qty_or;
            end
         end
         CMD_ERASE: begin
            if (!hit_any) begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Result register: load on execute, hold while stalled, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      arg_ff <= arg_in;
      if (exec) begin
         status_ff <= status_in;
         name_ff   <= name_in;
         qty_ff    <= qty_in;
      end
   end

   // Row of cells; cell 0 has no lower neighbor, the last cell no upper one.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic    occupied;
      logic    prev_below;
      rec_type prev_rec;
      rec_type next_rec;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign prev_below = 1'b1;
         assign prev_rec   = recs[i];
      end else begin : g_inner
         assign prev_below = flags[i-1].below;
         assign prev_rec   = recs[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_rec = recs[i];
      end else begin : g_body
         assign next_rec = recs[i+1];
      end

      srkt_cell u_cell (
         .clock      (clock),
         .occupied   (occupied),
         .ctrl       (ctrl),
         .prev_below (prev_below),
         .prev_rec   (prev_rec),
         .next_rec   (next_rec),
         .flags      (flags[i]),
         .rec        (recs[i]),
         .hit_name   (hit_names[i]),
         .hit_qty    (hit_qtys[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_name = name_ff;
   assign rsp_quantity   = qty_ff;

endmodule

[hdl/srkt_cell.sv]
// ----------------------------------------------------------------------------
// Record cell
// Holds one record, compares it with the broadcast key and shifts with its
// neighbors on insert and erase.
// ----------------------------------------------------------------------------
module srkt_cell (
   input  logic                  clock,
   input  logic                  occupied,
   input  srkt_pkg::cell_ctrl_type ctrl,
   input  logic                  prev_below,
   input  srkt_pkg::rec_type     prev_rec,
   input  srkt_pkg::rec_type     next_rec,
   output srkt_pkg::cell_flag_type flags,
   output srkt_pkg::rec_type     rec,
   output logic [srkt_pkg::NAME_W-1:0] hit_name,
   output logic [srkt_pkg::QTY_W-1:0]  hit_qty
);
   import srkt_pkg::*;

   rec_type          rec_ff;
   rec_type          rec_in;
   logic [QTY_W:0]   sum_wide;
   logic [QTY_W-1:0] sum_sat;

   assign flags.below = occupied && (rec_ff.key < ctrl.new_rec.key);
   assign flags.hit   = occupied && (rec_ff.key == ctrl.new_rec.key);

   // Saturating add of the change to the stored quantity.
   assign sum_wide = {rec_ff.qty[QTY_W-1], rec_ff.qty} +
                     {ctrl.new_rec.qty[QTY_W-1], ctrl.new_rec.qty};

   always_comb begin
      if (sum_wide[QTY_W] != sum_wide[QTY_W-1]) begin
         sum_sat = sum_wide[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}}
                                   : {1'b0, {(QTY_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[QTY_W-1:0];
      end
   end

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.insert_go && !flags.below) begin
         rec_in = prev_below ? ctrl.new_rec : prev_rec;
      end else if (ctrl.erase_go && !flags.below) begin
         rec_in = next_rec;
      end else if (ctrl.update_go && flags.hit) begin
         rec_in.qty = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec      = rec_ff;
   assign hit_name = flags.hit ? rec_ff.name : '0;
   assign hit_qty  = flags.hit ? (ctrl.update_go ? sum_sat : rec_ff.qty) : '0;

endmodule

[hdl/srkt_checker.sv]
// ----------------------------------------------------------------------------
// Sorted keyed record table port checker
// Watches the top-level ports for result ordering and result content rules.
// ----------------------------------------------------------------------------
module srkt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic [31:0]        rsp_found_name,
   input logic signed [31:0] rsp_quantity
);
   import srkt_pkg::*;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] pending_ff, pending_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Track transactions accepted but not yet answered.
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_found_name) && $stable(rsp_quantity))
      else $error("result changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_found_name == '0) && (rsp_quantity == '0))
      else $error("failed transaction returned nonzero fields");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0) && (pending_ff <= 2'd2))
      else $error("result without a matching transaction or too many in flight");

endmodule

bind sorted_keyed_record_table_top srkt_checker u_srkt_checker (.*);
